@@ hdl/slru_pkg.sv @@
// ----------------------------------------------------------------------------
// slru_pkg
// Shared types, constants and helpers of the set-associative LRU cache.
// ----------------------------------------------------------------------------
package slru_pkg;

  // Geometry limits
  localparam int ADDR_BITS        = 16;
  localparam int MAX_WAYS         = 8;
  localparam int MAX_SETS         = 64;
  localparam int MAX_BLOCK_BYTES  = 64;
  localparam int MAX_ACCESS_BYTES = 8;

  // Derived widths; storage rows are eight bytes wide
  localparam int OFF_W    = $clog2(MAX_BLOCK_BYTES);
  localparam int SET_W    = $clog2(MAX_SETS);
  localparam int WAY_W    = $clog2(MAX_WAYS);
  localparam int TAG_W    = ADDR_BITS - 2;
  localparam int RANK_W   = WAY_W;
  localparam int WORD_W   = OFF_W - 3;
  localparam int MROW_W   = ADDR_BITS - 3;
  localparam int LROW_W   = SET_W + WAY_W + WORD_W;
  localparam int CNT_W    = 4;
  localparam int DATA_W   = 64;
  localparam int MAX_OB   = $clog2(MAX_BLOCK_BYTES);
  localparam int MAX_IB   = $clog2(MAX_SETS);

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WRITE_BACK  = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_INDEX_BITS  = 2'd2,
    REG_WAYS_IN_USE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic       write_back;
    logic [2:0] offset_bits;
    logic [2:0] index_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  // Classified request passed from the front to the back
  typedef struct packed {
    logic                 store;
    logic [ADDR_BITS-1:0] address;
    logic [CNT_W-1:0]     byte_count;
    logic [DATA_W-1:0]    store_data;
    logic                 fault;
    logic [OFF_W-1:0]     offset;
    logic [SET_W-1:0]     set_idx;
    logic [TAG_W-1:0]     tag;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_data;
    logic              fault;
  } rsp_t;

  // Per-set bookkeeping row
  typedef struct packed {
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
  } meta_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'd0,
    ST_IDLE   = 4'd1,
    ST_LOOKUP = 4'd2,
    ST_WB     = 4'd3,
    ST_STMEM  = 4'd4,
    ST_FILL   = 4'd5,
    ST_RD     = 4'd6,
    ST_WR     = 4'd7,
    ST_RESP   = 4'd8
  } state_t;

  // One bit per accessed byte, count of 1 to 8
  function automatic logic [7:0] count_mask(input logic [CNT_W-1:0] n);
    logic [8:0] one_hot;
    one_hot = 9'd1 << n;
    return 8'(one_hot - 9'd1);
  endfunction

  // Byte mask widened to bit mask
  function automatic logic [DATA_W-1:0] expand_mask(input logic [7:0] m);
    logic [DATA_W-1:0] r;
    for (int b = 0; b < 8; b++) begin
      r[b*8 +: 8] = {8{m[b]}};
    end
    return r;
  endfunction

endpackage

@@ hdl/slru_fifo.sv @@
// ----------------------------------------------------------------------------
// slru_fifo
// Two-entry queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module slru_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

endmodule

@@ hdl/slru_front.sv @@
// ----------------------------------------------------------------------------
// slru_front
// Splits an incoming access into tag, set and offset and flags faults.
// ----------------------------------------------------------------------------
module slru_front
  import slru_pkg::*;
(
  input  cfg_t                 cfg,
  input  logic                 command,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [CNT_W-1:0]     byte_count,
  input  logic [DATA_W-1:0]    store_data,
  output req_t                 req
);

  logic [7:0]           bsz;
  logic [7:0]           blk_mask;
  logic [7:0]           set_mask;
  logic [3:0]           tag_shift;
  logic [ADDR_BITS-1:0] set_sh;
  logic [ADDR_BITS-1:0] tag_sh;
  logic [OFF_W-1:0]     offset;
  logic [7:0]           last_end;

  // Address split under the current geometry
  always_comb begin
    bsz       = 8'd1 << cfg.offset_bits;
    blk_mask  = bsz - 8'd1;
    set_mask  = (8'd1 << cfg.index_bits) - 8'd1;
    tag_shift = 4'(cfg.offset_bits) + 4'(cfg.index_bits);
    set_sh    = address >> cfg.offset_bits;
    tag_sh    = address >> tag_shift;
    offset    = address[OFF_W-1:0] & blk_mask[OFF_W-1:0];
    last_end  = 8'(offset) + 8'(byte_count);
  end

  // Classified request
  always_comb begin
    req.store      = (command == CMD_STORE);
    req.address    = address;
    req.byte_count = byte_count;
    req.store_data = store_data;
    req.offset     = offset;
    req.set_idx    = set_sh[SET_W-1:0] & set_mask[SET_W-1:0];
    req.tag        = tag_sh[TAG_W-1:0];
    req.fault      = (byte_count == '0)
                  || (byte_count > CNT_W'(MAX_ACCESS_BYTES))
                  || (last_end > bsz);
  end

endmodule

@@ hdl/slru_back.sv @@
// ----------------------------------------------------------------------------
// slru_back
// Carries out one request at a time: tag lookup, victim copy-back, store to
// memory, block fill and line access, over the line and backing memories.
// ----------------------------------------------------------------------------
module slru_back
  import slru_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  req_t         req,
  input  logic         req_empty,
  output logic         req_pop,
  output rsp_t         rsp,
  output logic         rsp_push,
  input  logic         rsp_full,
  output back_status_t status
);

  // Memories
  logic [DATA_W-1:0] bmem [2**MROW_W];
  logic [DATA_W-1:0] lmem [2**LROW_W];
  meta_t             meta [MAX_SETS];

  logic              b_we;
  logic [7:0]        b_be;
  logic [MROW_W-1:0] b_waddr;
  logic [MROW_W-1:0] b_raddr;
  logic [DATA_W-1:0] b_wdata;
  logic [DATA_W-1:0] b_rdata;
  logic              l_we;
  logic [7:0]        l_be;
  logic [LROW_W-1:0] l_waddr;
  logic [LROW_W-1:0] l_raddr;
  logic [DATA_W-1:0] l_wdata;
  logic [DATA_W-1:0] l_rdata;
  logic              meta_we;
  logic [SET_W-1:0]  meta_waddr;
  logic [SET_W-1:0]  meta_raddr;
  meta_t             meta_wdata;
  meta_t             meta_rdata;

  // Control and payload registers
  state_t            state, state_next;
  req_t              cur, cur_next;
  logic [WAY_W-1:0]  way_q, way_next;
  logic              hit_q, hit_next;
  logic              needwb_q, needwb_next;
  logic [TAG_W-1:0]  vtag_q, vtag_next;
  logic [3:0]        step, step_next;
  logic              pend, pend_next;
  logic [WORD_W-1:0] pend_i, pend_i_next;
  logic [MROW_W-1:0] clr, clr_next;
  logic [DATA_W-1:0] lo, lo_next;
  logic [DATA_W-1:0] hi, hi_next;

  // Derived geometry of the current request
  logic [7:0]             bsz;
  logic                   small_blk;
  logic [3:0]             nrows;
  logic [31:0]            wb_wide;
  logic [ADDR_BITS-1:0]   wb_addr;
  logic [ADDR_BITS-1:0]   blk_addr;
  logic [7:0]             acc_mask;
  logic [2:0]             lsh;
  logic [2:0]             bsh;
  logic [15:0]            lbe;
  logic [15:0]            bbe;
  logic [2*DATA_W-1:0]    ldat;
  logic [2*DATA_W-1:0]    bdat;
  logic [2*DATA_W-1:0]    rwin;
  logic [WORD_W-1:0]      word0;
  logic [MROW_W-1:0]      brow0;

  always_comb begin
    bsz       = 8'd1 << cfg.offset_bits;
    small_blk = (cfg.offset_bits < 3'd3);
    nrows     = small_blk ? 4'd1 : (4'd1 << (cfg.offset_bits - 3'd3));
    wb_wide   = (32'(vtag_q) << (4'(cfg.offset_bits) + 4'(cfg.index_bits)))
              | (32'(cur.set_idx) << cfg.offset_bits);
    wb_addr   = wb_wide[ADDR_BITS-1:0];
    blk_addr  = cur.address & ~ADDR_BITS'(bsz - 8'd1);
    acc_mask  = count_mask(cur.byte_count);
    lsh       = cur.offset[2:0];
    bsh       = cur.address[2:0];
    lbe       = 16'(acc_mask) << lsh;
    bbe       = 16'(acc_mask) << bsh;
    ldat      = (2*DATA_W)'(cur.store_data) << {lsh, 3'b000};
    bdat      = (2*DATA_W)'(cur.store_data) << {bsh, 3'b000};
    rwin      = {hi, lo} >> {lsh, 3'b000};
    word0     = cur.offset[OFF_W-1:3];
    brow0     = cur.address[ADDR_BITS-1:3];
  end

  // Set lookup: hit way, first free way, least recently used way
  logic             hit_any, free_any;
  logic [WAY_W-1:0] hit_way, free_way, lru_way, sel_way;
  logic [RANK_W-1:0] sel_rank;
  meta_t            meta_upd;

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    for (int k = MAX_WAYS - 1; k >= 0; k--) begin
      if (4'(k) < cfg.ways_in_use) begin
        if (meta_rdata.valid[k] && (meta_rdata.tag[k] == cur.tag)) begin
          hit_any = 1'b1;
          hit_way = WAY_W'(k);
        end
        if (!meta_rdata.valid[k]) begin
          free_any = 1'b1;
          free_way = WAY_W'(k);
        end
      end
    end
    for (int k = 1; k < MAX_WAYS; k++) begin
      if ((4'(k) < cfg.ways_in_use) && (meta_rdata.rank[k] > meta_rdata.rank[lru_way])) begin
        lru_way = WAY_W'(k);
      end
    end
    sel_way  = hit_any ? hit_way : (free_any ? free_way : lru_way);
    sel_rank = meta_rdata.rank[sel_way];
    meta_upd = meta_rdata;
    // Ranks younger than the touched way age by one
    for (int u = 0; u < MAX_WAYS; u++) begin
      if ((4'(u) < cfg.ways_in_use) && (meta_rdata.rank[u] < sel_rank)) begin
        meta_upd.rank[u] = meta_rdata.rank[u] + RANK_W'(1);
      end
    end
    meta_upd.rank[sel_way]  = '0;
    meta_upd.tag[sel_way]   = cur.tag;
    meta_upd.valid[sel_way] = 1'b1;
  end

  // Reset value of a bookkeeping row
  meta_t meta_init;
  always_comb begin
    meta_init = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      meta_init.rank[w] = RANK_W'(w);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Other registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      pend  <= 1'b0;
      clr   <= '0;
    end else begin
      step  <= step_next;
      pend  <= pend_next;
      clr   <= clr_next;
    end
    cur      <= cur_next;
    way_q    <= way_next;
    hit_q    <= hit_next;
    needwb_q <= needwb_next;
    vtag_q   <= vtag_next;
    pend_i   <= pend_i_next;
    lo       <= lo_next;
    hi       <= hi_next;
  end

  // Next state and memory controls
  always_comb begin
    state_next  = state;
    cur_next    = cur;
    way_next    = way_q;
    hit_next    = hit_q;
    needwb_next = needwb_q;
    vtag_next   = vtag_q;
    step_next   = step;
    pend_next   = pend;
    pend_i_next = pend_i;
    clr_next    = clr;
    lo_next     = lo;
    hi_next     = hi;
    req_pop     = 1'b0;
    rsp_push    = 1'b0;
    b_we        = 1'b0;
    b_be        = '0;
    b_waddr     = brow0;
    b_wdata     = bdat[DATA_W-1:0];
    b_raddr     = blk_addr[ADDR_BITS-1:3] + MROW_W'(step);
    l_we        = 1'b0;
    l_be        = '0;
    l_waddr     = {cur.set_idx, way_q, word0};
    l_wdata     = ldat[DATA_W-1:0];
    l_raddr     = {cur.set_idx, way_q, word0};
    meta_we     = 1'b0;
    meta_waddr  = cur.set_idx;
    meta_wdata  = meta_upd;
    meta_raddr  = req.set_idx;

    unique case (state)
      // Zero the backing memory and reset the bookkeeping rows
      ST_CLEAR: begin
        b_we       = 1'b1;
        b_be       = '1;
        b_waddr    = clr;
        b_wdata    = '0;
        meta_we    = (clr < MROW_W'(MAX_SETS));
        meta_waddr = clr[SET_W-1:0];
        meta_wdata = meta_init;
        clr_next   = clr + MROW_W'(1);
        if (clr == '1) state_next = ST_IDLE;
      end

      // Take the next request; its set row is read meanwhile
      ST_IDLE: begin
        if (!req_empty) begin
          req_pop    = 1'b1;
          cur_next   = req;
          hit_next   = 1'b0;
          state_next = req.fault ? ST_RESP : ST_LOOKUP;
        end
      end

      // Choose the way and update tag, valid and recency
      ST_LOOKUP: begin
        meta_we     = 1'b1;
        way_next    = sel_way;
        hit_next    = hit_any;
        vtag_next   = meta_rdata.tag[sel_way];
        needwb_next = !hit_any && !free_any && cfg.write_back;
        step_next   = '0;
        pend_next   = 1'b0;
        if (hit_any) begin
          state_next = cur.store ? ST_WR : ST_RD;
        end else if (!free_any && cfg.write_back) begin
          state_next = ST_WB;
        end else begin
          state_next = cur.store ? ST_STMEM : ST_FILL;
        end
      end

      // Copy the victim block back, one row per cycle
      ST_WB: begin
        l_raddr = {cur.set_idx, way_q, step[WORD_W-1:0]};
        if (pend) begin
          b_we    = 1'b1;
          b_waddr = wb_addr[ADDR_BITS-1:3] + MROW_W'(pend_i);
          if (small_blk) begin
            b_be    = wb_addr[2] ? 8'hF0 : 8'h0F;
            b_wdata = {l_rdata[31:0], l_rdata[31:0]};
          end else begin
            b_be    = '1;
            b_wdata = l_rdata;
          end
        end
        if (step < nrows) begin
          pend_next   = 1'b1;
          pend_i_next = step[WORD_W-1:0];
          step_next   = step + 4'd1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            step_next  = '0;
            state_next = cur.store ? ST_STMEM : ST_FILL;
          end
        end
      end

      // Store miss writes memory before the fill
      ST_STMEM: begin
        b_we = 1'b1;
        if (step == 4'd0) begin
          b_waddr   = brow0;
          b_be      = bbe[7:0];
          b_wdata   = bdat[DATA_W-1:0];
          step_next = 4'd1;
        end else begin
          b_waddr    = brow0 + MROW_W'(1);
          b_be       = bbe[15:8];
          b_wdata    = bdat[2*DATA_W-1:DATA_W];
          step_next  = '0;
          pend_next  = 1'b0;
          state_next = ST_FILL;
        end
      end

      // Fill the line from memory, one row per cycle
      ST_FILL: begin
        if (pend) begin
          l_we    = 1'b1;
          l_waddr = {cur.set_idx, way_q, pend_i};
          if (small_blk) begin
            l_be    = 8'h0F;
            l_wdata = blk_addr[2] ? {32'd0, b_rdata[63:32]} : b_rdata;
          end else begin
            l_be    = '1;
            l_wdata = b_rdata;
          end
        end
        if (step < nrows) begin
          pend_next   = 1'b1;
          pend_i_next = step[WORD_W-1:0];
          step_next   = step + 4'd1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            step_next  = '0;
            state_next = cur.store ? ST_RESP : ST_RD;
          end
        end
      end

      // Read the row that holds the first byte and the row after it
      ST_RD: begin
        case (step)
          4'd0: begin
            step_next = 4'd1;
          end
          4'd1: begin
            lo_next   = l_rdata;
            l_raddr   = {cur.set_idx, way_q, word0 + WORD_W'(1)};
            step_next = 4'd2;
          end
          default: begin
            hi_next    = l_rdata;
            step_next  = '0;
            state_next = ST_RESP;
          end
        endcase
      end

      // Store hit: line always, memory too in write-through mode
      ST_WR: begin
        l_we = 1'b1;
        b_we = !cfg.write_back;
        if (step == 4'd0) begin
          l_be      = lbe[7:0];
          b_be      = bbe[7:0];
          step_next = 4'd1;
        end else begin
          l_waddr    = {cur.set_idx, way_q, word0 + WORD_W'(1)};
          l_be       = lbe[15:8];
          l_wdata    = ldat[2*DATA_W-1:DATA_W];
          b_waddr    = brow0 + MROW_W'(1);
          b_be       = bbe[15:8];
          b_wdata    = bdat[2*DATA_W-1:DATA_W];
          step_next  = '0;
          state_next = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!rsp_full) begin
          rsp_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Result item
  always_comb begin
    rsp.hit       = hit_q;
    rsp.fault     = cur.fault;
    rsp.read_data = (cur.store || cur.fault) ? '0
                  : (rwin[DATA_W-1:0] & expand_mask(acc_mask));
  end

  assign status.clearing = (state == ST_CLEAR);

  // Backing memory
  always_ff @(posedge clk) begin
    if (b_we) begin
      for (int b = 0; b < 8; b++) begin
        if (b_be[b]) bmem[b_waddr][b*8 +: 8] <= b_wdata[b*8 +: 8];
      end
    end
    b_rdata <= bmem[b_raddr];
  end

  // Line memory
  always_ff @(posedge clk) begin
    if (l_we) begin
      for (int b = 0; b < 8; b++) begin
        if (l_be[b]) lmem[l_waddr][b*8 +: 8] <= l_wdata[b*8 +: 8];
      end
    end
    l_rdata <= lmem[l_raddr];
  end

  // Bookkeeping memory
  always_ff @(posedge clk) begin
    if (meta_we) meta[meta_waddr] <= meta_wdata;
    meta_rdata <= meta[meta_raddr];
  end

`ifndef SYNTHESIS
  a_rsp_room: assert property (@(posedge clk) disable iff (rst)
    rsp_push |-> !rsp_full)
    else $error("result pushed into a full queue");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !req_pop)
    else $error("item taken during clearing pass");

  a_way_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL || state == ST_RD || state == ST_WR)
      |-> ({1'b0, way_q} < cfg.ways_in_use))
    else $error("selected way not in use");

  a_wb_on_miss: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> (needwb_q && !hit_q))
    else $error("copy-back without a full-set miss");
`endif

endmodule

@@ hdl/set_associative_lru_cache.sv @@
// ----------------------------------------------------------------------------
// set_associative_lru_cache
// Set-associative cache with LRU replacement over a 64 KiB byte memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: push an item (command, address, byte_count, store_data)
//   while full is low. Result queue: hit, read_data and fault of the oldest
//   result stand while empty is low; pop takes them. One result per item,
//   in order. Configuration is written through cfg_write/cfg_index/cfg_data
//   while no item is in flight.
//   Handling: items are handled one at a time by the back end. A load miss
//   adds a fill of the block from the backing memory; a store miss writes
//   the backing memory and then fills the block, its memory write standing
//   in for the line write; evicting from a full set in write-back mode
//   adds a copy-back of the victim block.
//   A two-entry queue on each side lets the input accept while a result
//   waits; when the receiver stalls both queues fill and full rises.
//   Reset: a clearing pass zeroes the backing memory one row per cycle,
//   holding full high; configuration writes are still taken.
// ----------------------------------------------------------------------------
module set_associative_lru_cache
  import slru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 command,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [CNT_W-1:0]     byte_count,
  input  logic [DATA_W-1:0]    store_data,
  output logic                 empty,
  input  logic                 pop,
  output logic                 hit,
  output logic [DATA_W-1:0]    read_data,
  output logic                 fault,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [3:0]           cfg_data
);

  cfg_t         cfg;
  req_t         front_req;
  req_t         back_req;
  logic         req_full;
  logic         req_empty;
  logic         req_pop;
  rsp_t         back_rsp;
  rsp_t         out_rsp;
  logic         rsp_push;
  logic         rsp_full;
  back_status_t status;

  // Configuration registers, saturated to the supported range
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_back  <= 1'b1;
      cfg.offset_bits <= 3'd2;
      cfg.index_bits  <= 3'(MAX_IB);
      cfg.ways_in_use <= 4'(MAX_WAYS);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_WRITE_BACK:  cfg.write_back <= cfg_data[0];
        REG_OFFSET_BITS: cfg.offset_bits <= (cfg_data[2:0] < 3'd2) ? 3'd2
                          : ((cfg_data[2:0] > 3'(MAX_OB)) ? 3'(MAX_OB) : cfg_data[2:0]);
        REG_INDEX_BITS:  cfg.index_bits <= (cfg_data[2:0] > 3'(MAX_IB)) ? 3'(MAX_IB)
                          : cfg_data[2:0];
        REG_WAYS_IN_USE: cfg.ways_in_use <= (cfg_data == 4'd0) ? 4'd1
                          : ((cfg_data > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : cfg_data);
        default: ;
      endcase
    end
  end

  assign full = req_full || status.clearing;

  slru_front u_front (
    .cfg        (cfg),
    .command    (command),
    .address    (address),
    .byte_count (byte_count),
    .store_data (store_data),
    .req        (front_req)
  );

  slru_fifo #(.WIDTH($bits(req_t))) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .wdata (front_req),
    .full  (req_full),
    .pop   (req_pop),
    .rdata (back_req),
    .empty (req_empty)
  );

  slru_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (back_req),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .rsp       (back_rsp),
    .rsp_push  (rsp_push),
    .rsp_full  (rsp_full),
    .status    (status)
  );

  slru_fifo #(.WIDTH($bits(rsp_t))) u_rsp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rsp_push),
    .wdata (back_rsp),
    .full  (rsp_full),
    .pop   (pop),
    .rdata (out_rsp),
    .empty (empty)
  );

  assign hit       = out_rsp.hit;
  assign read_data = out_rsp.read_data;
  assign fault     = out_rsp.fault;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives loads and stores through the set-associative LRU cache under several
// geometries and both store policies. A scoreboard keeps its own copy of the
// cache and backing memory, predicts each result and checks it on pop.
// ----------------------------------------------------------------------------
module tb_top;
  import slru_pkg::*;

  // Cache predictor and store of expected results
  class cache_scoreboard;
    logic [7:0]       mem_img [0:(1<<ADDR_BITS)-1];
    logic [7:0]       line_img [0:MAX_SETS*MAX_WAYS*MAX_BLOCK_BYTES-1];
    logic [TAG_W-1:0] tags [0:MAX_SETS*MAX_WAYS-1];
    bit               valid [0:MAX_SETS*MAX_WAYS-1];
    int unsigned      rank [0:MAX_SETS*MAX_WAYS-1];
    bit               wb_mode;
    int unsigned      ob, ib, ways;
    rsp_t             pending [$];
    int unsigned      errors;
    int unsigned      hits, misses, faults;

    function new();
      foreach (mem_img[i]) mem_img[i] = 8'h00;
      foreach (line_img[i]) line_img[i] = 8'h00;
      foreach (tags[i]) tags[i] = '0;
      foreach (valid[i]) valid[i] = 1'b0;
      foreach (rank[i]) rank[i] = i % MAX_WAYS;
      wb_mode = 1'b1; ob = 2; ib = 6; ways = 8;
      errors = 0; hits = 0; misses = 0; faults = 0;
    endfunction

    // Register write with saturation as in the block
    function void set_reg(reg_idx_t idx, logic [3:0] v);
      case (idx)
        REG_WRITE_BACK:  wb_mode = v[0];
        REG_OFFSET_BITS: ob = (v[2:0] < 2) ? 2 : ((v[2:0] > MAX_OB) ? MAX_OB : v[2:0]);
        REG_INDEX_BITS:  ib = (v[2:0] > MAX_IB) ? MAX_IB : v[2:0];
        default:         ways = (v == 0) ? 1 : ((v > MAX_WAYS) ? MAX_WAYS : v);
      endcase
    endfunction

    // Promote a way to most recently used
    function void promote(int unsigned base, int unsigned w);
      int unsigned r;
      r = rank[base+w];
      for (int u = 0; u < ways; u++)
        if (rank[base+u] < r) rank[base+u]++;
      rank[base+w] = 0;
    endfunction

    // Note an accepted item and predict its result
    function void note_access(logic cmd, logic [15:0] addr, logic [3:0] cnt,
                              logic [63:0] data);
      rsp_t r;
      int unsigned bsz, off, set_no, base, w, best;
      logic [TAG_W-1:0] tg;
      logic [15:0] wa, blk;
      bit found, full_set;
      r = '0;
      bsz = 1 << ob;
      off = addr & (bsz - 1);
      set_no = (addr >> ob) & ((1 << ib) - 1);
      tg = addr >> (ob + ib);
      base = set_no * MAX_WAYS;
      if (cnt == 0 || cnt > MAX_ACCESS_BYTES || off + cnt > bsz) begin
        r.fault = 1'b1;
        faults++;
        pending.push_back(r);
        return;
      end
      found = 0; w = 0;
      for (int k = 0; k < ways; k++)
        if (!found && valid[base+k] && tags[base+k] == tg) begin
          found = 1; w = k;
        end
      if (found) begin
        hits++;
        promote(base, w);
        for (int k = 0; k < cnt; k++) begin
          if (cmd == CMD_STORE) begin
            line_img[(base+w)*MAX_BLOCK_BYTES+off+k] = data[8*k +: 8];
            if (!wb_mode) mem_img[16'(addr+k)] = data[8*k +: 8];
          end else
            r.read_data[8*k +: 8] = line_img[(base+w)*MAX_BLOCK_BYTES+off+k];
        end
      end else begin
        misses++;
        full_set = 1;
        for (int k = 0; k < ways; k++)
          if (full_set && !valid[base+k]) begin
            full_set = 0; w = k;
          end
        if (full_set) begin
          best = 0;
          for (int k = 1; k < ways; k++)
            if (rank[base+k] > rank[base+best]) best = k;
          w = best;
          if (wb_mode) begin
            wa = 16'((tags[base+w] << (ob + ib)) | (set_no << ob));
            for (int k = 0; k < bsz; k++)
              mem_img[16'(wa+k)] = line_img[(base+w)*MAX_BLOCK_BYTES+k];
          end
        end
        if (cmd == CMD_STORE)
          for (int k = 0; k < cnt; k++) mem_img[16'(addr+k)] = data[8*k +: 8];
        blk = addr & ~16'(bsz - 1);
        for (int k = 0; k < bsz; k++)
          line_img[(base+w)*MAX_BLOCK_BYTES+k] = mem_img[16'(blk+k)];
        tags[base+w] = tg;
        valid[base+w] = 1'b1;
        promote(base, w);
        if (cmd == CMD_LOAD)
          for (int k = 0; k < cnt; k++)
            r.read_data[8*k +: 8] = line_img[(base+w)*MAX_BLOCK_BYTES+off+k];
      end
      r.hit = found;
      pending.push_back(r);
    endfunction

    // Check a popped result against the oldest prediction
    function void check_result(logic h, logic [63:0] rd, logic f);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: hit=%0b data=%h fault=%0b", h, rd, f);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h !== e.hit) begin
        $error("hit: expected %0b, got %0b", e.hit, h); errors++;
      end
      if (rd !== e.read_data) begin
        $error("read_data: expected %h, got %h", e.read_data, rd); errors++;
      end
      if (f !== e.fault) begin
        $error("fault: expected %0b, got %0b", e.fault, f); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0;
  logic full, empty;
  logic command = CMD_LOAD;
  logic [ADDR_BITS-1:0] address = '0;
  logic [CNT_W-1:0] byte_count = 4'd1;
  logic [DATA_W-1:0] store_data = '0;
  logic hit, fault;
  logic [DATA_W-1:0] read_data;
  logic cfg_write = 0;
  logic [1:0] cfg_index = REG_WRITE_BACK;
  logic [3:0] cfg_data = '0;

  cache_scoreboard sb = new();
  bit quiet_tail = 0;   // no idling at the end of the run
  bit sender_done = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_sent = 0;
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  set_associative_lru_cache dut (.*);

  always #5 clk = ~clk;

  // Result side: random stall bursts, sample at rising edge
  initial begin
    int unsigned gap;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(hit, read_data, fault);
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", stall_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [3:0] v);
    push <= 1'b0;
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Offer one item and hold it until taken; push stays high for a following item
  task automatic send_access(logic cmd, logic [15:0] addr, logic [3:0] cnt,
                             logic [63:0] data);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1; command <= cmd; address <= addr;
    byte_count <= cnt; store_data <= data;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_access(cmd, addr, cnt, data);
    items_sent++;
    @(negedge clk);
  endtask

  // Wait for every expected result, then let the back end settle
  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random access, mostly kept in a small window so sets refill and evict
  task automatic random_access(int unsigned window);
    logic [15:0] a;
    int unsigned bsz, cnt;
    bsz = 1 << sb.ob;
    a = 16'($urandom_range(0, window - 1));
    if ($urandom_range(0, 15) == 0) a = 16'($urandom());
    if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, 15);
    else begin
      cnt = $urandom_range(1, (bsz < 8) ? bsz : 8);
      a = a - (a % bsz) + $urandom_range(0, bsz - cnt);
    end
    send_access($urandom_range(0, 1), a, 4'(cnt), rand64());
  endtask

  initial begin
    int unsigned window;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every line completely once, so later geometries only read
    // line bytes that have been written
    write_reg(REG_OFFSET_BITS, 4'd6);
    for (int s = 0; s < MAX_SETS; s++)
      for (int t = 0; t < MAX_WAYS; t++)
        send_access(CMD_LOAD, 16'((t << 12) | (s << 6)), 4'd8, '0);
    drain();
    write_reg(REG_OFFSET_BITS, 4'd2);

    // Directed: field extremes, both commands, faults, bad counts
    send_access(CMD_STORE, 16'h0000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_STORE, 16'h0000, 4'd4, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_LOAD,  16'h0000, 4'd4, '0);
    send_access(CMD_STORE, 16'hFFFC, 4'd4, 64'hA5A5_5A5A_0123_4567);
    send_access(CMD_LOAD,  16'hFFFF, 4'd1, '0);
    send_access(CMD_LOAD,  16'hFFFD, 4'd4, '0);
    send_access(CMD_LOAD,  16'h0010, 4'd0, '0);
    send_access(CMD_LOAD,  16'h0010, 4'd15, '0);
    send_access(CMD_STORE, 16'h0010, 4'd9, rand64());
    for (int i = 0; i < 10; i++)   // same set, many tags: evictions in write-back
      send_access(i[0], 16'(i << 8), 4'd4, rand64());
    send_access(CMD_LOAD, 16'h0100, 4'd4, '0);
    send_access(CMD_LOAD, 16'h0000, 4'd4, '0);
    drain();

    // Phases over several geometries and both store policies
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_OFFSET_BITS, 4'd2); write_reg(REG_INDEX_BITS, 4'd0);
                 write_reg(REG_WAYS_IN_USE, 4'd1); write_reg(REG_WRITE_BACK, 4'd0); end
        1: begin write_reg(REG_OFFSET_BITS, 4'd6); write_reg(REG_INDEX_BITS, 4'd6);
                 write_reg(REG_WAYS_IN_USE, 4'd8); write_reg(REG_WRITE_BACK, 4'd1); end
        2: begin write_reg(REG_OFFSET_BITS, 4'd3); write_reg(REG_INDEX_BITS, 4'd1);
                 write_reg(REG_WAYS_IN_USE, 4'd2); end
        3: begin write_reg(REG_OFFSET_BITS, 4'd15); write_reg(REG_INDEX_BITS, 4'd7);
                 write_reg(REG_WAYS_IN_USE, 4'd15); write_reg(REG_WRITE_BACK, 4'd0); end
        4: begin write_reg(REG_OFFSET_BITS, 4'd0); write_reg(REG_INDEX_BITS, 4'd2);
                 write_reg(REG_WAYS_IN_USE, 4'd0); write_reg(REG_WRITE_BACK, 4'd1); end
        5: begin write_reg(REG_OFFSET_BITS, 4'd4); write_reg(REG_INDEX_BITS, 4'd3);
                 write_reg(REG_WAYS_IN_USE, 4'd4); end
        6: begin write_reg(REG_OFFSET_BITS, 4'd5); write_reg(REG_INDEX_BITS, 4'd0);
                 write_reg(REG_WAYS_IN_USE, 4'd3); write_reg(REG_WRITE_BACK, 4'd0); end
        default: begin write_reg(REG_OFFSET_BITS, 4'd2); write_reg(REG_INDEX_BITS, 4'd2);
                 write_reg(REG_WAYS_IN_USE, 4'd2); write_reg(REG_WRITE_BACK, 4'd1); end
      endcase
      // Lines kept from earlier geometries may hit; all their bytes were
      // filled at the start, so the predictor and the block agree on them
      window = (1 << (sb.ob + sb.ib)) * 4;
      if (window > 4096) window = 4096;
      if (phase == 7) quiet_tail = 1;
      for (int i = 0; i < 120; i++) begin
        random_access(window);
        if (i == 60) drain();   // sender holds off until all results are in
      end
      drain();
    end

    $display("%0d items: %0d hits, %0d misses, %0d faults", items_sent,
             sb.hits, sb.misses, sb.faults);
    $display("full line fill, then 8 geometries incl. size extremes, both store policies");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
